// File: sv/mwm_pkg.sv
// Mecanum wheel mixer package: widths, payload types and lane indexes.
// Used by mecanum_wheel_mixer. No dependencies.
package mwm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int CMD_W     = 16;
    localparam int W_W       = 18;
    localparam int MAG_W     = 17;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int RES_W     = (Q_W > MAG_W) ? Q_W : MAG_W;
    localparam int CMP_W     = (FRAC_BITS + 2 > MAG_W) ? FRAC_BITS + 2 : MAG_W;
    localparam int DIV_N     = Q_W + 1;
    localparam int NST       = DIV_N + 3;
    localparam int LANES     = 4;

    localparam logic [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

    localparam int FL = 0;
    localparam int FR = 1;
    localparam int RL = 2;
    localparam int RR = 3;

    typedef logic signed [IN_W-1:0]  stick_t;
    typedef logic signed [CMD_W-1:0] cmd_t;
    typedef logic signed [W_W-1:0]   wsum_t;
    typedef logic [MAG_W-1:0]        mag_t;

    typedef struct packed {
        logic           neg;
        mag_t           mag;
        mag_t           rem;
        logic [Q_W-1:0] quot;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        mag_t              maxv;
        logic              scaled;
    } div_t;

endpackage

// File: sv/mecanum_wheel_mixer.sv
// Mecanum wheel mixer: joystick sample to four normalized wheel commands.
// Depends on mwm_pkg (widths, payload types, pipeline depth).
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_ready, stick_y, stick_x, stick_twist | in
//  out     | out_valid, out_ready, front_left_cmd, front_right_cmd,
//          | rear_left_cmd, rear_right_cmd, was_scaled          | out
//
// One request per cycle while the output is not stalled; the stages are:
// mix, magnitude, max, one restoring-divider stage per quotient bit, output.
// The divider chain sets the depth. Reset clears only the stage valid bits.
// A stage holds only when it is full and the stage after it holds, so bubbles
// collapse and requests keep entering while a result waits at the output.
module mecanum_wheel_mixer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mwm_pkg::stick_t stick_y,
    input  mwm_pkg::stick_t stick_x,
    input  mwm_pkg::stick_t stick_twist,
    output logic           out_valid,
    input  logic           out_ready,
    output mwm_pkg::cmd_t  front_left_cmd,
    output mwm_pkg::cmd_t  front_right_cmd,
    output mwm_pkg::cmd_t  rear_left_cmd,
    output mwm_pkg::cmd_t  rear_right_cmd,
    output logic           was_scaled
);
    import mwm_pkg::*;

    function automatic div_t div_step(input div_t d, input logic first);
        div_t           r;
        logic [MAG_W:0] trial;
        logic           bin;
        r = d;
        for (int k = 0; k < LANES; k++)
        begin
            bin   = first ? d.lane[k].mag[0] : 1'b0;
            trial = {d.lane[k].rem, bin};
            if (trial >= {1'b0, d.maxv})
            begin
                r.lane[k].rem  = MAG_W'(trial - {1'b0, d.maxv});
                r.lane[k].quot = {d.lane[k].quot[Q_W-2:0], 1'b1};
            end
            else
            begin
                r.lane[k].rem  = trial[MAG_W-1:0];
                r.lane[k].quot = {d.lane[k].quot[Q_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] valid_prev;
    logic [NST:0]   adv;

    wsum_t mix_reg  [LANES];
    wsum_t mix_next [LANES];
    mag_t  mag_reg  [LANES];
    mag_t  mag_next [LANES];
    logic  neg_reg  [LANES];
    logic  neg_next [LANES];
    div_t  div_reg  [DIV_N];
    div_t  div_next [DIV_N];
    cmd_t  cmd_reg  [LANES];
    cmd_t  cmd_next [LANES];
    logic  scaled_reg;
    logic  scaled_next;

    wsum_t fwd;
    wsum_t strafe;
    wsum_t turn;
    wsum_t absw [LANES];
    mag_t  max01;
    mag_t  max23;
    mag_t  maxv;
    logic [RES_W-1:0] res [LANES];
    logic [RES_W-1:0] sres [LANES];

    // stage handshake chain
    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_adv
            assign adv[g] = ~valid_reg[g] | adv[g+1];
        end
    endgenerate
    assign adv[NST] = out_ready;

    assign valid_prev = {valid_reg[NST-2:0], in_valid};
    assign valid_next = (adv[NST-1:0] & valid_prev) | (~adv[NST-1:0] & valid_reg);

    // mix
    always_comb
    begin
        fwd    = -wsum_t'(stick_y);
        strafe = wsum_t'(stick_x);
        turn   = wsum_t'(stick_twist);
        mix_next[FL] = fwd + turn + strafe;
        mix_next[FR] = fwd - turn - strafe;
        mix_next[RL] = fwd + turn - strafe;
        mix_next[RR] = fwd - turn + strafe;
    end

    // magnitude and sign
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            neg_next[k] = mix_reg[k][W_W-1];
            absw[k]     = neg_next[k] ? -mix_reg[k] : mix_reg[k];
            mag_next[k] = absw[k][MAG_W-1:0];
        end
    end

    // largest magnitude, divider seed, divider steps
    always_comb
    begin
        max01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        max23 = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        maxv  = (max01 > max23) ? max01 : max23;
        div_next[0].maxv   = maxv;
        div_next[0].scaled = CMP_W'(maxv) > ONE;
        for (int k = 0; k < LANES; k++)
        begin
            div_next[0].lane[k].neg  = neg_reg[k];
            div_next[0].lane[k].mag  = mag_reg[k];
            div_next[0].lane[k].rem  = mag_reg[k] >> 1;
            div_next[0].lane[k].quot = '0;
        end
        for (int j = 1; j < DIV_N; j++)
        begin
            div_next[j] = div_step(div_reg[j-1], j == 1);
        end
    end

    // sign restore, select, wrap to command width
    always_comb
    begin
        scaled_next = div_reg[DIV_N-1].scaled;
        for (int k = 0; k < LANES; k++)
        begin
            res[k]  = scaled_next ? RES_W'(div_reg[DIV_N-1].lane[k].quot)
                                  : RES_W'(div_reg[DIV_N-1].lane[k].mag);
            sres[k] = div_reg[DIV_N-1].lane[k].neg ? -res[k] : res[k];
            cmd_next[k] = sres[k][CMD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mix_reg <= mix_next;
        end
        if (adv[1])
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
        for (int j = 0; j < DIV_N; j++)
        begin
            if (adv[j+2])
            begin
                div_reg[j] <= div_next[j];
            end
        end
        if (adv[NST-1])
        begin
            cmd_reg    <= cmd_next;
            scaled_reg <= scaled_next;
        end
    end

    assign in_ready        = adv[0];
    assign out_valid       = valid_reg[NST-1];
    assign front_left_cmd  = cmd_reg[FL];
    assign front_right_cmd = cmd_reg[FR];
    assign rear_left_cmd   = cmd_reg[RL];
    assign rear_right_cmd  = cmd_reg[RR];
    assign was_scaled      = scaled_reg;

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted request not captured in mix stage");

    a_max_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] |-> div_reg[0].lane[0].mag <= div_reg[0].maxv
                      && div_reg[0].lane[1].mag <= div_reg[0].maxv
                      && div_reg[0].lane[2].mag <= div_reg[0].maxv
                      && div_reg[0].lane[3].mag <= div_reg[0].maxv)
        else $error("lane magnitude above selected maximum");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NST-2] && div_reg[DIV_N-1].scaled
        |-> div_reg[DIV_N-1].lane[0].rem < div_reg[DIV_N-1].maxv
         && div_reg[DIV_N-1].lane[1].rem < div_reg[DIV_N-1].maxv
         && div_reg[DIV_N-1].lane[2].rem < div_reg[DIV_N-1].maxv
         && div_reg[DIV_N-1].lane[3].rem < div_reg[DIV_N-1].maxv)
        else $error("divider remainder not below divisor");

    a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_scaled && (FRAC_BITS <= 14)
        |-> front_left_cmd  <= $signed(CMD_W'(ONE)) && front_left_cmd  >= -$signed(CMD_W'(ONE))
         && front_right_cmd <= $signed(CMD_W'(ONE)) && front_right_cmd >= -$signed(CMD_W'(ONE))
         && rear_left_cmd   <= $signed(CMD_W'(ONE)) && rear_left_cmd   >= -$signed(CMD_W'(ONE))
         && rear_right_cmd  <= $signed(CMD_W'(ONE)) && rear_right_cmd  >= -$signed(CMD_W'(ONE)))
        else $error("scaled command outside unit range");

endmodule

// File: tb/mecanum_wheel_mixer_test.sv
// Testbench for mecanum_wheel_mixer: directed corner samples, then random joystick
// requests under several sender/receiver idle mixes, checked against a local mixer model.
// Depends on mwm_pkg and mecanum_wheel_mixer.
module mecanum_wheel_mixer_test;
    import mwm_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        cmd_t fl;
        cmd_t fr;
        cmd_t rl;
        cmd_t rr;
        logic scaled;
    } wheel_cmds_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    stick_t stick_y = '0;
    stick_t stick_x = '0;
    stick_t stick_twist = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    cmd_t   front_left_cmd;
    cmd_t   front_right_cmd;
    cmd_t   rear_left_cmd;
    cmd_t   rear_right_cmd;
    logic   was_scaled;

    wheel_cmds_t pending_cmds[$];
    int gap_pct = 0;
    int stall_pct = 0;
    int n_requests = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_scaled = 0;
    int idle_cycles = 0;

    mecanum_wheel_mixer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stick_y        (stick_y),
        .stick_x        (stick_x),
        .stick_twist    (stick_twist),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .front_left_cmd (front_left_cmd),
        .front_right_cmd(front_right_cmd),
        .rear_left_cmd  (rear_left_cmd),
        .rear_right_cmd (rear_right_cmd),
        .was_scaled     (was_scaled)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Normalized mecanum mix; division truncates toward zero.
    function automatic wheel_cmds_t mix_wheels(stick_t y, stick_t x, stick_t t);
        wheel_cmds_t res;
        longint one;
        longint fwd;
        longint strafe;
        longint turn;
        longint w[4];
        longint a;
        longint m;
        one    = longint'(1) << FRAC_BITS;
        fwd    = -longint'(y);
        strafe = longint'(x);
        turn   = longint'(t);
        w[FL] = fwd + turn + strafe;
        w[FR] = fwd - turn - strafe;
        w[RL] = fwd + turn - strafe;
        w[RR] = fwd - turn + strafe;
        m = 0;
        for (int i = 0; i < LANES; i++)
        begin
            a = (w[i] < 0) ? -w[i] : w[i];
            if (a > m)
                m = a;
        end
        res.scaled = (m > one);
        if (res.scaled)
        begin
            for (int i = 0; i < LANES; i++)
                w[i] = (w[i] * one) / m;
        end
        res.fl = cmd_t'(w[FL]);
        res.fr = cmd_t'(w[FR]);
        res.rl = cmd_t'(w[RL]);
        res.rr = cmd_t'(w[RR]);
        return res;
    endfunction

    function automatic stick_t random_axis();
        stick_t v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = stick_t'(int'($urandom_range(32768)) - 16384);
            6, 7:             v = stick_t'($urandom);
            8:
            begin
                case ($urandom_range(4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = 16'sd16384;
                    3:       v = -16'sd16384;
                    default: v = '0;
                endcase
            end
            default:          v = stick_t'(int'($urandom_range(64)) - 32);
        endcase
        return v;
    endfunction

    task automatic send_request(stick_t y, stick_t x, stick_t t);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid    <= 1'b1;
        stick_y     <= y;
        stick_x     <= x;
        stick_twist <= t;
        do @(posedge clk); while (!in_ready);
        pending_cmds.push_back(mix_wheels(y, x, t));
        n_requests++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(string field, logic signed [15:0] want, logic signed [15:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_result
        wheel_cmds_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got fl %0d fr %0d rl %0d rr %0d",
                         $time, front_left_cmd, front_right_cmd, rear_left_cmd, rear_right_cmd);
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("front_left_cmd", want.fl, front_left_cmd);
                check_field("front_right_cmd", want.fr, front_right_cmd);
                check_field("rear_left_cmd", want.rl, rear_left_cmd);
                check_field("rear_right_cmd", want.rr, rear_right_cmd);
                check_field("was_scaled", {15'b0, want.scaled}, {15'b0, was_scaled});
                if (want.scaled)
                    n_scaled++;
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_pct == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_cmds.size());
                $display("mecanum_wheel_mixer test failed");
                $finish;
            end
        end
    end

    // Zero, unit axes, magnitude exactly one, just over one, full-scale and out-of-range.
    task automatic test_directed_corners();
        gap_pct   = 0;
        stall_pct = 0;
        send_request(16'sd0, 16'sd0, 16'sd0);
        send_request(-16'sd16384, 16'sd0, 16'sd0);
        send_request(16'sd16384, 16'sd0, 16'sd0);
        send_request(16'sd0, 16'sd16384, 16'sd0);
        send_request(16'sd0, -16'sd16384, 16'sd0);
        send_request(16'sd0, 16'sd0, 16'sd16384);
        send_request(16'sd0, 16'sd0, -16'sd16384);
        send_request(-16'sd16384, 16'sd1, 16'sd0);
        send_request(-16'sd16384, 16'sd16384, 16'sd16384);
        send_request(16'sd16384, -16'sd16384, -16'sd16384);
        send_request(16'sh8000, 16'sd0, 16'sd0);
        send_request(16'sh8000, 16'sh8000, 16'sh8000);
        send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_request(16'sh8000, 16'sh7fff, 16'sh8000);
        send_request(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_request(-16'sd8192, 16'sd8192, 16'sd0);
        send_request(-16'sd1, 16'sd1, 16'sd1);
        send_request(16'sd1, -16'sd1, -16'sd1);
        send_request(16'sd12345, -16'sd6789, 16'sd4321);
        send_request(-16'sd16384, -16'sd16384, 16'sd16384);
    endtask

    task automatic test_random_traffic(int count, int gap, int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count)
            send_request(random_axis(), random_axis(), random_axis());
    endtask

    // Sender holds off until the pipeline is empty, then resumes.
    task automatic test_drain_pause();
        gap_pct   = 0;
        stall_pct = 36;
        repeat (12)
            send_request(random_axis(), random_axis(), random_axis());
        wait_drained();
        repeat (12)
            send_request(random_axis(), random_axis(), random_axis());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_traffic(150, 0, 0);
        test_random_traffic(150, 85, 0);
        test_random_traffic(150, 0, 85);
        test_drain_pause();
        test_random_traffic(150, 36, 36);
        wait_drained();
        repeat (NST + 10) @(posedge clk);
        $display("Sent %0d joystick requests (corners, free flow, sparse input, output stall,",
                 n_requests);
        $display("  drain pause, mixed); %0d results compared, %0d of them scaled down",
                 n_checked, n_scaled);
        if (n_errors == 0)
            $display("mecanum_wheel_mixer test passed");
        else
            $display("mecanum_wheel_mixer test failed");
        $finish;
    end

endmodule
